FILE: src/dldm_pkg.sv
package dldm_pkg;

    localparam int POOL_NODES_DEF = 256;

    localparam logic [3:0] REQ_PUSH_BACK     = 4'd0;
    localparam logic [3:0] REQ_PUSH_FRONT    = 4'd1;
    localparam logic [3:0] REQ_INSERT_AFTER  = 4'd2;
    localparam logic [3:0] REQ_INSERT_BEFORE = 4'd3;
    localparam logic [3:0] REQ_POP_FRONT     = 4'd4;
    localparam logic [3:0] REQ_POP_BACK      = 4'd5;
    localparam logic [3:0] REQ_REMOVE        = 4'd6;
    localparam logic [3:0] REQ_PEEK          = 4'd7;
    localparam logic [3:0] REQ_LENGTH        = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef logic [2:0] t_sel;

    // Sources for link addresses, link data and list registers.
    localparam t_sel SEL_NODE   = 3'd0;
    localparam t_sel SEL_ANCHOR = 3'd1;
    localparam t_sel SEL_HEAD   = 3'd2;
    localparam t_sel SEL_TAIL   = 3'd3;
    localparam t_sel SEL_NXD    = 3'd4;
    localparam t_sel SEL_PVD    = 3'd5;
    localparam t_sel SEL_CUR    = 3'd6;
    localparam t_sel SEL_NONE   = 3'd7;

    typedef struct packed {
        logic       load;
        logic       nx_we;
        t_sel       nx_wa;
        t_sel       nx_wd;
        t_sel       nx_ra;
        logic       pv_we;
        t_sel       pv_wa;
        t_sel       pv_wd;
        t_sel       pv_ra;
        logic       head_we;
        t_sel       head_sel;
        logic       tail_we;
        t_sel       tail_sel;
        logic       cnt_up;
        logic       cnt_dn;
        logic       cur_we;
        t_sel       cur_sel;
        logic       walk_clr;
        logic       walk_inc;
        logic       res_we;
        t_sel       res_sel;
        logic       res_valid;
        logic [1:0] res_status;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic [3:0] req;
        logic       node_oor;
        logic       anchor_oor;
        logic       head_none;
        logic       tail_none;
        logic       anchor_is_tail;
        logic       nxd_none;
        logic       pvd_none;
        logic       cur_none;
        logic       peek_oor;
        logic       walk_done;
        logic       out_free;
    } t_stat;

endpackage

FILE: src/dldm_ram.sv
module dldm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/dldm_datapath.sv
module dldm_datapath
    import dldm_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_s_tdata,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tuser
);

    localparam int LW = $clog2(POOL_NODES + 1);
    localparam int AW = $clog2(POOL_NODES);
    localparam logic [LW-1:0] NONE = LW'(POOL_NODES);

    logic [3:0]    r_req;
    logic [LW-1:0] r_node;
    logic [LW-1:0] r_anchor;
    logic [7:0]    r_index;
    logic          r_node_oor;
    logic          r_anchor_oor;
    logic [LW-1:0] r_head;
    logic [LW-1:0] r_tail;
    logic [LW-1:0] r_count;
    logic [LW-1:0] r_cur;
    logic [7:0]    r_walk;
    logic [LW-1:0] r_res;
    logic          r_res_valid;
    logic [1:0]    r_res_status;
    logic          r_nx_rnone;
    logic          r_pv_rnone;
    logic          r_out_valid;
    logic [7:0]    r_out_node;
    logic          r_out_nvalid;
    logic [8:0]    r_out_len;
    logic [1:0]    r_out_status;

    logic [LW-1:0] nx_rdata;
    logic [LW-1:0] pv_rdata;
    logic [LW-1:0] nxd;
    logic [LW-1:0] pvd;
    logic [LW-1:0] nx_wa_v;
    logic [LW-1:0] nx_wd_v;
    logic [LW-1:0] nx_ra_v;
    logic [LW-1:0] pv_wa_v;
    logic [LW-1:0] pv_wd_v;
    logic [LW-1:0] pv_ra_v;
    logic          nx_we;
    logic          pv_we;

    // A read at the none marker returns the none marker.
    assign nxd = r_nx_rnone ? NONE : nx_rdata;
    assign pvd = r_pv_rnone ? NONE : pv_rdata;

    function automatic logic [LW-1:0] pick(input t_sel s);
        logic [LW-1:0] v;
        case (s)
            SEL_NODE:   v = r_node;
            SEL_ANCHOR: v = r_anchor;
            SEL_HEAD:   v = r_head;
            SEL_TAIL:   v = r_tail;
            SEL_NXD:    v = nxd;
            SEL_PVD:    v = pvd;
            SEL_CUR:    v = r_cur;
            default:    v = NONE;
        endcase
        return v;
    endfunction

    function automatic logic in_pool(input logic [LW-1:0] v);
        return 32'(v) < POOL_NODES;
    endfunction

    always_comb begin
        nx_wa_v = pick(i_cmd.nx_wa);
        nx_wd_v = pick(i_cmd.nx_wd);
        nx_ra_v = pick(i_cmd.nx_ra);
        pv_wa_v = pick(i_cmd.pv_wa);
        pv_wd_v = pick(i_cmd.pv_wd);
        pv_ra_v = pick(i_cmd.pv_ra);
        nx_we   = i_cmd.nx_we && in_pool(nx_wa_v);
        pv_we   = i_cmd.pv_we && in_pool(pv_wa_v);
    end

    dldm_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (AW'(nx_wa_v)),
        .i_wdata (nx_wd_v),
        .i_raddr (AW'(nx_ra_v)),
        .o_rdata (nx_rdata)
    );

    dldm_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (AW'(pv_wa_v)),
        .i_wdata (pv_wd_v),
        .i_raddr (AW'(pv_ra_v)),
        .o_rdata (pv_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_nx_rnone <= !in_pool(nx_ra_v);
        r_pv_rnone <= !in_pool(pv_ra_v);
        if (i_cmd.load) begin
            r_req        <= i_s_tdata[3:0];
            r_node       <= LW'(i_s_tdata[11:4]);
            r_anchor     <= LW'(i_s_tdata[19:12]);
            r_index      <= i_s_tdata[27:20];
            r_node_oor   <= 32'(i_s_tdata[11:4]) >= POOL_NODES;
            r_anchor_oor <= 32'(i_s_tdata[19:12]) >= POOL_NODES;
        end
        if (i_cmd.cur_we) begin
            r_cur <= pick(i_cmd.cur_sel);
        end
        if (i_cmd.walk_clr) begin
            r_walk <= 8'd0;
        end else if (i_cmd.walk_inc) begin
            r_walk <= r_walk + 8'd1;
        end
        if (i_cmd.res_we) begin
            r_res        <= pick(i_cmd.res_sel);
            r_res_valid  <= i_cmd.res_valid;
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.emit) begin
            r_out_node   <= r_res_valid ? 8'(r_res) : 8'd0;
            r_out_nvalid <= r_res_valid;
            r_out_len    <= 9'(r_count);
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NONE;
            r_tail      <= NONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.head_we) begin
                r_head <= pick(i_cmd.head_sel);
            end
            if (i_cmd.tail_we) begin
                r_tail <= pick(i_cmd.tail_sel);
            end
            if (i_cmd.cnt_up && r_count != NONE) begin
                r_count <= r_count + LW'(1);
            end else if (i_cmd.cnt_dn && r_count != '0) begin
                r_count <= r_count - LW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.req            = r_req;
        o_stat.node_oor       = r_node_oor;
        o_stat.anchor_oor     = r_anchor_oor;
        o_stat.head_none      = r_head == NONE;
        o_stat.tail_none      = r_tail == NONE;
        o_stat.anchor_is_tail = r_anchor == r_tail;
        o_stat.nxd_none       = nxd == NONE;
        o_stat.pvd_none       = pvd == NONE;
        o_stat.cur_none       = r_cur == NONE;
        o_stat.peek_oor       = 32'(r_index) >= 32'(r_count);
        o_stat.walk_done      = r_walk == r_index;
        o_stat.out_free       = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_status, r_out_len, r_out_node};
    assign o_m_tuser  = r_out_nvalid;

endmodule

FILE: src/dldm_ctrl.sv
module dldm_ctrl
    import dldm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_PB1    = 4'd2;
    localparam logic [3:0] S_PB2    = 4'd3;
    localparam logic [3:0] S_PF1    = 4'd4;
    localparam logic [3:0] S_PF2    = 4'd5;
    localparam logic [3:0] S_IA2    = 4'd6;
    localparam logic [3:0] S_IA3    = 4'd7;
    localparam logic [3:0] S_IB2    = 4'd8;
    localparam logic [3:0] S_IB3    = 4'd9;
    localparam logic [3:0] S_POPF2  = 4'd10;
    localparam logic [3:0] S_POPB2  = 4'd11;
    localparam logic [3:0] S_RM2    = 4'd12;
    localparam logic [3:0] S_RM3    = 4'd13;
    localparam logic [3:0] S_WALK   = 4'd14;
    localparam logic [3:0] S_WALK2  = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_emit_wait;
    logic       n_emit_wait;

    assign o_s_tready = (r_state == S_IDLE) && !r_emit_wait;

    always_comb begin
        o_cmd       = '0;
        o_cmd.nx_ra = SEL_NONE;
        o_cmd.pv_ra = SEL_NONE;
        n_state     = r_state;
        n_emit_wait = r_emit_wait;
        // A finished request waits here until the output register is free.
        if (r_emit_wait) begin
            if (i_stat.out_free) begin
                o_cmd.emit  = 1'b1;
                n_emit_wait = 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DECODE;
                    end
                end
                S_DECODE: begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_sel    = SEL_NONE;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_IDLE;
                    n_emit_wait      = 1'b1;
                    case (i_stat.req)
                        REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                            if (i_stat.node_oor) begin
                                o_cmd.res_status = ST_RANGE;
                            end else begin
                                n_emit_wait = 1'b0;
                                n_state = (i_stat.req == REQ_PUSH_BACK) ? S_PB1 : S_PF1;
                            end
                        end
                        REQ_INSERT_AFTER, REQ_INSERT_BEFORE: begin
                            if (i_stat.node_oor || i_stat.anchor_oor) begin
                                o_cmd.res_status = ST_RANGE;
                            end else if (i_stat.head_none) begin
                                o_cmd.res_status = ST_EMPTY;
                            end else if (i_stat.req == REQ_INSERT_BEFORE) begin
                                o_cmd.pv_ra = SEL_ANCHOR;
                                n_emit_wait = 1'b0;
                                n_state     = S_IB2;
                            end else if (i_stat.anchor_is_tail) begin
                                n_emit_wait = 1'b0;
                                n_state     = S_PB1;
                            end else begin
                                o_cmd.nx_ra = SEL_ANCHOR;
                                n_emit_wait = 1'b0;
                                n_state     = S_IA2;
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (i_stat.head_none) begin
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.res_sel   = SEL_HEAD;
                                o_cmd.res_valid = 1'b1;
                                o_cmd.nx_ra     = SEL_HEAD;
                                n_emit_wait     = 1'b0;
                                n_state         = S_POPF2;
                            end
                        end
                        REQ_POP_BACK: begin
                            if (i_stat.tail_none) begin
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.res_sel   = SEL_TAIL;
                                o_cmd.res_valid = 1'b1;
                                o_cmd.pv_ra     = SEL_TAIL;
                                n_emit_wait     = 1'b0;
                                n_state         = S_POPB2;
                            end
                        end
                        REQ_REMOVE: begin
                            if (i_stat.node_oor) begin
                                o_cmd.res_status = ST_RANGE;
                            end else if (i_stat.head_none) begin
                                o_cmd.res_status = ST_EMPTY;
                            end else begin
                                o_cmd.nx_ra = SEL_NODE;
                                o_cmd.pv_ra = SEL_NODE;
                                n_emit_wait = 1'b0;
                                n_state     = S_RM2;
                            end
                        end
                        REQ_PEEK: begin
                            if (i_stat.peek_oor) begin
                                o_cmd.res_status = ST_RANGE;
                            end else begin
                                o_cmd.cur_we   = 1'b1;
                                o_cmd.cur_sel  = SEL_HEAD;
                                o_cmd.walk_clr = 1'b1;
                                n_emit_wait    = 1'b0;
                                n_state        = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_PB1: begin
                    o_cmd.nx_we = 1'b1;
                    o_cmd.nx_wa = SEL_TAIL;
                    o_cmd.nx_wd = SEL_NODE;
                    o_cmd.pv_we = 1'b1;
                    o_cmd.pv_wa = SEL_NODE;
                    o_cmd.pv_wd = SEL_TAIL;
                    n_state     = S_PB2;
                end
                S_PB2: begin
                    o_cmd.nx_we    = 1'b1;
                    o_cmd.nx_wa    = SEL_NODE;
                    o_cmd.nx_wd    = SEL_NONE;
                    o_cmd.tail_we  = 1'b1;
                    o_cmd.tail_sel = SEL_NODE;
                    o_cmd.head_we  = i_stat.head_none;
                    o_cmd.head_sel = SEL_NODE;
                    o_cmd.cnt_up   = 1'b1;
                    n_state        = S_IDLE;
                    n_emit_wait    = 1'b1;
                end
                S_PF1: begin
                    o_cmd.nx_we = 1'b1;
                    o_cmd.nx_wa = SEL_NODE;
                    o_cmd.nx_wd = SEL_HEAD;
                    o_cmd.pv_we = 1'b1;
                    o_cmd.pv_wa = SEL_HEAD;
                    o_cmd.pv_wd = SEL_NODE;
                    n_state     = S_PF2;
                end
                S_PF2: begin
                    o_cmd.pv_we    = 1'b1;
                    o_cmd.pv_wa    = SEL_NODE;
                    o_cmd.pv_wd    = SEL_NONE;
                    o_cmd.head_we  = 1'b1;
                    o_cmd.head_sel = SEL_NODE;
                    o_cmd.tail_we  = i_stat.tail_none;
                    o_cmd.tail_sel = SEL_NODE;
                    o_cmd.cnt_up   = 1'b1;
                    n_state        = S_IDLE;
                    n_emit_wait    = 1'b1;
                end
                S_IA2: begin
                    // The old successor of the anchor is kept for the next step.
                    o_cmd.cur_we  = 1'b1;
                    o_cmd.cur_sel = SEL_NXD;
                    o_cmd.pv_we   = 1'b1;
                    o_cmd.pv_wa   = SEL_NODE;
                    o_cmd.pv_wd   = SEL_ANCHOR;
                    o_cmd.nx_we   = 1'b1;
                    o_cmd.nx_wa   = SEL_NODE;
                    o_cmd.nx_wd   = SEL_NXD;
                    n_state       = S_IA3;
                end
                S_IA3: begin
                    o_cmd.nx_we  = 1'b1;
                    o_cmd.nx_wa  = SEL_ANCHOR;
                    o_cmd.nx_wd  = SEL_NODE;
                    o_cmd.pv_we  = 1'b1;
                    o_cmd.pv_wa  = SEL_CUR;
                    o_cmd.pv_wd  = SEL_NODE;
                    o_cmd.cnt_up = 1'b1;
                    n_state      = S_IDLE;
                    n_emit_wait  = 1'b1;
                end
                S_IB2: begin
                    o_cmd.pv_we    = 1'b1;
                    o_cmd.pv_wa    = SEL_NODE;
                    o_cmd.pv_wd    = SEL_PVD;
                    o_cmd.nx_we    = 1'b1;
                    o_cmd.nx_wa    = SEL_PVD;
                    o_cmd.nx_wd    = SEL_NODE;
                    o_cmd.head_we  = i_stat.pvd_none;
                    o_cmd.head_sel = SEL_NODE;
                    n_state        = S_IB3;
                end
                S_IB3: begin
                    o_cmd.pv_we  = 1'b1;
                    o_cmd.pv_wa  = SEL_ANCHOR;
                    o_cmd.pv_wd  = SEL_NODE;
                    o_cmd.nx_we  = 1'b1;
                    o_cmd.nx_wa  = SEL_NODE;
                    o_cmd.nx_wd  = SEL_ANCHOR;
                    o_cmd.cnt_up = 1'b1;
                    n_state      = S_IDLE;
                    n_emit_wait  = 1'b1;
                end
                S_POPF2: begin
                    o_cmd.head_we  = 1'b1;
                    o_cmd.head_sel = SEL_NXD;
                    o_cmd.pv_we    = 1'b1;
                    o_cmd.pv_wa    = SEL_NXD;
                    o_cmd.pv_wd    = SEL_NONE;
                    o_cmd.tail_we  = i_stat.nxd_none;
                    o_cmd.tail_sel = SEL_NONE;
                    o_cmd.cnt_dn   = 1'b1;
                    n_state        = S_IDLE;
                    n_emit_wait    = 1'b1;
                end
                S_POPB2: begin
                    o_cmd.tail_we  = 1'b1;
                    o_cmd.tail_sel = SEL_PVD;
                    o_cmd.nx_we    = 1'b1;
                    o_cmd.nx_wa    = SEL_PVD;
                    o_cmd.nx_wd    = SEL_NONE;
                    o_cmd.head_we  = i_stat.pvd_none;
                    o_cmd.head_sel = SEL_NONE;
                    o_cmd.cnt_dn   = 1'b1;
                    n_state        = S_IDLE;
                    n_emit_wait    = 1'b1;
                end
                S_RM2: begin
                    o_cmd.nx_we    = 1'b1;
                    o_cmd.nx_wa    = SEL_PVD;
                    o_cmd.nx_wd    = SEL_NXD;
                    o_cmd.head_we  = i_stat.pvd_none;
                    o_cmd.head_sel = SEL_NXD;
                    o_cmd.pv_we    = 1'b1;
                    o_cmd.pv_wa    = SEL_NXD;
                    o_cmd.pv_wd    = SEL_PVD;
                    o_cmd.tail_we  = i_stat.nxd_none;
                    o_cmd.tail_sel = SEL_PVD;
                    n_state        = S_RM3;
                end
                S_RM3: begin
                    o_cmd.nx_we  = 1'b1;
                    o_cmd.nx_wa  = SEL_NODE;
                    o_cmd.nx_wd  = SEL_NONE;
                    o_cmd.pv_we  = 1'b1;
                    o_cmd.pv_wa  = SEL_NODE;
                    o_cmd.pv_wd  = SEL_NONE;
                    o_cmd.cnt_dn = 1'b1;
                    n_state      = S_IDLE;
                    n_emit_wait  = 1'b1;
                end
                S_WALK: begin
                    if (i_stat.cur_none || i_stat.walk_done) begin
                        o_cmd.res_we     = 1'b1;
                        o_cmd.res_sel    = SEL_CUR;
                        o_cmd.res_valid  = !i_stat.cur_none;
                        o_cmd.res_status = i_stat.cur_none ? ST_RANGE : ST_OK;
                        n_state          = S_IDLE;
                        n_emit_wait      = 1'b1;
                    end else begin
                        o_cmd.nx_ra = SEL_CUR;
                        n_state     = S_WALK2;
                    end
                end
                S_WALK2: begin
                    o_cmd.cur_we   = 1'b1;
                    o_cmd.cur_sel  = SEL_NXD;
                    o_cmd.walk_inc = 1'b1;
                    n_state        = S_WALK;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_emit_wait <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_emit_wait <= n_emit_wait;
        end
    end

endmodule

FILE: src/doubly_linked_deque_manager.sv
// Channel   Direction  Ports                          Contents (lowest bit up)
// request   in         i_s_tvalid/o_s_tready/i_s_tdata req_type, node, anchor, index
// result    out        o_m_tvalid/i_m_tready/o_m_tdata node_out, list_length, status
//                      o_m_tuser                       node_valid
//
// One request at a time. Pushes, inserts and removes write their links over
// successive states, as each link RAM has a single write port. A peek walks
// the list from the head: each link step is one registered RAM read.
// Reset clears head, tail and count; the link RAMs are not cleared.
// A result waiting in the output register holds the next result back until taken.
module doubly_linked_deque_manager
    import dldm_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // req_type[3:0], node[11:4], anchor[19:12], index[27:20], zero fill
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // node_out[7:0], list_length[16:8], status[18:17], zero fill
    output logic [23:0] o_m_tdata,
    // node_valid[0]
    output logic        o_m_tuser
);

    t_cmd  cmd;
    t_stat stat;

    dldm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dldm_datapath #(.POOL_NODES(POOL_NODES)) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
